### rtl/mhbp_pkg.sv
// Shared types and constants of the max-heap build and preorder readout block.
package mhbp_pkg;

  // Width of one data value.
  localparam int unsigned VALUE_W = 32;

  // Datapath operation selected by the controller for the current cycle.
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_PAR,
    OP_CUR,
    OP_RC,
    OP_CMP,
    OP_LC,
    OP_ERD,
    OP_EDN,
    OP_EUP,
    OP_EOUT
  } op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_e  op;
    logic accept;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic par_zero;
    logic has_lc;
    logic descend;
    logic up_stop;
    logic out_busy;
    logic more;
    logic cnt_zero;
  } status_t;

endpackage

### rtl/mhbp_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface mhbp_in_if;
  import mhbp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic                       last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface mhbp_out_if;
  import mhbp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value_res;
  logic                       last_res;
  logic                       dropped;

  modport source (output valid, output value_res, output last_res, output dropped,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input dropped,
                output ready);
endinterface

### rtl/mhbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mhbp_dp.sv
// Datapath: element store, sift-down compare, preorder walk and output register.
module mhbp_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mhbp_pkg::cmd_t                     cmd_i,
  output mhbp_pkg::status_t                  status_o,
  input  logic signed [mhbp_pkg::VALUE_W-1:0] in_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mhbp_pkg::VALUE_W-1:0] out_value_o,
  output logic                               out_last_o,
  output logic                               out_dropped_o
);
  import mhbp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(MAX_ITEMS);

  // Control registers.
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] par_q, par_d;
  logic [CW-1:0] node_q, node_d;
  logic [CW-1:0] w_q, w_d;
  logic          more_q, more_d;
  logic          out_valid_q, out_valid_d;

  // Payload registers.
  logic signed [VALUE_W-1:0] cur_q, cur_d;
  logic signed [VALUE_W-1:0] lval_q, lval_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic                      out_last_q, out_last_d;
  logic                      out_drop_q, out_drop_d;

  // Store access.
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic signed [VALUE_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic signed [VALUE_W-1:0] rd_data;

  // Index arithmetic and comparisons.
  logic [CW:0]               lc_idx;
  logic [CW:0]               rc_idx;
  logic [CW:0]               cnt_x;
  logic [CW:0]               w_inc;
  logic [CW-1:0]             par_m1;
  logic [CW-1:0]             cnt_ld;
  logic                      full;
  logic                      has_lc;
  logic                      has_rc;
  logic                      lgt;
  logic                      rgt;
  logic signed [VALUE_W-1:0] best1;
  logic                      up_stop;
  logic                      out_busy;

  mhbp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_data = $signed(ram_rdata);

  // Child indices of the current node and the tree size.
  assign lc_idx  = {node_q, 1'b1};
  assign rc_idx  = {node_q, 1'b0} + (CW + 1)'(2);
  assign cnt_x   = {1'b0, cnt_q};
  assign has_lc  = lc_idx < cnt_x;
  assign has_rc  = rc_idx < cnt_x;
  assign par_m1  = par_q - CW'(1);
  assign full    = (cnt_q == CAP_CNT);
  assign cnt_ld  = full ? cnt_q : cnt_q + CW'(1);

  // Pick the larger child; a child wins only when strictly larger, left first.
  assign lgt     = lval_q > cur_q;
  assign best1   = lgt ? lval_q : cur_q;
  assign rgt     = has_rc && (rd_data > best1);

  // Preorder climb: stop at the root or at a left child with a right sibling.
  assign w_inc   = {1'b0, w_q} + (CW + 1)'(1);
  assign up_stop = (w_q == '0) || (w_q[0] && (w_inc < cnt_x));

  assign out_busy = out_valid_q && !out_ready_i;

  // Store port control per operation.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_q[AW-1:0];
    ram_wdata = cur_q;
    ram_re    = 1'b0;
    ram_raddr = node_q[AW-1:0];
    case (cmd_i.op)
      OP_LOAD: begin
        if (cmd_i.accept && !full) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AW-1:0];
          ram_wdata = in_value_i;
        end
      end
      OP_PAR: begin
        ram_re    = (par_q != '0);
        ram_raddr = par_m1[AW-1:0];
      end
      OP_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = lc_idx[AW-1:0];
      end
      OP_RC: begin
        ram_re    = has_rc;
        ram_raddr = rc_idx[AW-1:0];
      end
      OP_CMP: begin
        // Move the winner up, or settle the sifted value here.
        ram_we    = 1'b1;
        ram_wdata = rgt ? rd_data : best1;
      end
      OP_LC: begin
        if (has_lc) begin
          ram_re    = 1'b1;
          ram_raddr = lc_idx[AW-1:0];
        end else begin
          ram_we    = 1'b1;
        end
      end
      OP_ERD: begin
        ram_re    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next-state logic of the datapath registers.
  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    par_d       = par_q;
    node_d      = node_q;
    w_d         = w_q;
    more_d      = more_q;
    cur_d       = cur_q;
    lval_d      = lval_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    case (cmd_i.op)
      OP_LOAD: begin
        if (cmd_i.accept) begin
          cnt_d = cnt_ld;
          par_d = cnt_ld >> 1;
          if (full) begin
            ovf_d = 1'b1;
          end
        end
      end
      OP_PAR: begin
        if (par_q != '0) begin
          par_d  = par_m1;
          node_d = par_m1;
        end else begin
          node_d = '0;
        end
      end
      OP_CUR: begin
        cur_d = rd_data;
      end
      OP_RC: begin
        lval_d = rd_data;
      end
      OP_CMP: begin
        if (rgt) begin
          node_d = rc_idx[CW-1:0];
        end else if (lgt) begin
          node_d = lc_idx[CW-1:0];
        end
      end
      OP_EDN: begin
        if (has_lc) begin
          w_d    = lc_idx[CW-1:0];
          more_d = 1'b1;
        end else begin
          w_d    = node_q;
          more_d = 1'b0;
        end
      end
      OP_EUP: begin
        if (w_q == '0) begin
          more_d = 1'b0;
        end else if (w_q[0] && (w_inc < cnt_x)) begin
          w_d    = w_inc[CW-1:0];
          more_d = 1'b1;
        end else begin
          w_d    = (w_q - CW'(1)) >> 1;
        end
      end
      OP_EOUT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_value_d = rd_data;
          out_last_d  = !more_q;
          out_drop_d  = ovf_q;
          node_d      = w_q;
          if (!more_q) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      par_q       <= '0;
      node_q      <= '0;
      w_q         <= '0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      par_q       <= par_d;
      node_q      <= node_d;
      w_q         <= w_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    lval_q      <= lval_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  assign status_o.par_zero = (par_q == '0);
  assign status_o.has_lc   = has_lc;
  assign status_o.descend  = lgt || rgt;
  assign status_o.up_stop  = up_stop;
  assign status_o.out_busy = out_busy;
  assign status_o.more     = more_q;
  assign status_o.cnt_zero = (cnt_q == '0);

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_last_o    = out_last_q;
  assign out_dropped_o = out_drop_q;

endmodule

### rtl/mhbp_ctrl.sv
// Controller: sequences loading, bottom-up sift-down and preorder emission.
module mhbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  mhbp_pkg::status_t status_i,
  output mhbp_pkg::cmd_t    cmd_o
);
  import mhbp_pkg::*;

  typedef enum logic [9:0] {
    ST_LOAD = 10'b00_0000_0001,
    ST_PAR  = 10'b00_0000_0010,
    ST_CUR  = 10'b00_0000_0100,
    ST_RC   = 10'b00_0000_1000,
    ST_CMP  = 10'b00_0001_0000,
    ST_LC   = 10'b00_0010_0000,
    ST_ERD  = 10'b00_0100_0000,
    ST_EDN  = 10'b00_1000_0000,
    ST_EUP  = 10'b01_0000_0000,
    ST_EOUT = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  // State transitions.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && in_last_i) begin
          state_d = ST_PAR;
        end
      end
      ST_PAR: begin
        state_d = status_i.par_zero ? ST_ERD : ST_CUR;
      end
      ST_CUR: begin
        state_d = ST_RC;
      end
      ST_RC: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = status_i.descend ? ST_LC : ST_PAR;
      end
      ST_LC: begin
        state_d = status_i.has_lc ? ST_RC : ST_PAR;
      end
      ST_ERD: begin
        state_d = ST_EDN;
      end
      ST_EDN: begin
        state_d = status_i.has_lc ? ST_EOUT : ST_EUP;
      end
      ST_EUP: begin
        if (status_i.up_stop) begin
          state_d = ST_EOUT;
        end
      end
      ST_EOUT: begin
        if (!status_i.out_busy) begin
          state_d = status_i.more ? ST_ERD : ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Operation for the datapath.
  always_comb begin
    cmd_o.accept = accept;
    case (state_q)
      ST_LOAD: cmd_o.op = OP_LOAD;
      ST_PAR:  cmd_o.op = OP_PAR;
      ST_CUR:  cmd_o.op = OP_CUR;
      ST_RC:   cmd_o.op = OP_RC;
      ST_CMP:  cmd_o.op = OP_CMP;
      ST_LC:   cmd_o.op = OP_LC;
      ST_ERD:  cmd_o.op = OP_ERD;
      ST_EDN:  cmd_o.op = OP_EDN;
      ST_EUP:  cmd_o.op = OP_EUP;
      ST_EOUT: cmd_o.op = OP_EOUT;
      default: cmd_o.op = OP_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/max_heap_build_preorder.sv
// Max-heap build with preorder readout: loads a set, heapifies it, emits it.
// Loading accepts one input beat per cycle; the beat marked last starts the build.
// Build: for each parent, last first, read it and its children, compare, and sink it level by level.
// Emission: read each node, step to its left child, or climb from a leaf to the next right sibling.
// Output stalls hold emission back. Input waits until done.
// Reset clears the controller, count and flags; the store needs no clearing.
module max_heap_build_preorder #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhbp_in_if.sink    in_i,
  mhbp_out_if.source out_o
);
  import mhbp_pkg::*;

  cmd_t    cmd;
  status_t st;

  mhbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  mhbp_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (st),
    .in_value_i    (in_i.value),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_value_o   (out_o.value_res),
    .out_last_o    (out_o.last_res),
    .out_dropped_o (out_o.dropped)
  );

`ifndef SYNTHESIS
  // The final beat of a run leaves the count empty for the next set.
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EOUT && !st.out_busy && !st.more) |=> st.cnt_zero)
    else $error("count not cleared after final beat");

  // A build never works on an empty store.
  a_build_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_PAR) |-> !st.cnt_zero)
    else $error("heap build started on empty store");

  // A result handed to the output register is presented in the next cycle.
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EOUT && !st.out_busy) |=> out_o.valid)
    else $error("output register not loaded");
`endif

endmodule
